// ===== src/dssm_pkg.sv =====
// ----------------------------------------------------------------------------
// dssm_pkg: shared types and codes for the dual stack shared memory
// Operation codes, status codes and the interface field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dssm_pkg;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_MODIFY = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    localparam int unsigned FIELD_DATA_BITS = 32;
    localparam int unsigned FIELD_FILL_BITS = 8;
    localparam int unsigned FIELD_POS_BITS  = 8;

endpackage : dssm_pkg

// ===== src/dual_stack_shared_memory.sv =====
// ----------------------------------------------------------------------------
// dual_stack_shared_memory: two stacks in one synchronous memory
// Push, modify and every failing transaction give their result in the
// output register in the cycle after acceptance; pop and peek read the
// memory into its read register (S_READ), then fill the output register
// once it is free. Throughput: one transaction every cycle for push/modify/failures
// while the output is not stalled; pop/peek hold the input until their data is loaded.
// Reset clears both fill counts and the output valid; memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_stack_shared_memory
    import dssm_pkg::*;
#(
    parameter int unsigned DEPTH     = 128,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_mode,
    input  logic                              i_stack_sel,
    input  logic signed [FIELD_DATA_BITS-1:0] i_value,
    input  logic [FIELD_POS_BITS-1:0]         i_position,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic signed [FIELD_DATA_BITS-1:0] o_data,
    output logic [FIELD_FILL_BITS-1:0]        o_fill_low,
    output logic [FIELD_FILL_BITS-1:0]        o_fill_high
);

    // count width holds 0..DEPTH, address width indexes 0..DEPTH-1
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // compare width for position against a fill count
    localparam int unsigned PW = (CW > FIELD_POS_BITS) ? CW : FIELD_POS_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // shared storage: bottom-up stack from entry 0, top-down from DEPTH-1
    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    t_state               r_state;
    logic [CW-1:0]        r_count_low;
    logic [CW-1:0]        r_count_high;
    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic [FIELD_DATA_BITS-1:0] r_data;
    logic [FIELD_FILL_BITS-1:0] r_fill_low;
    logic [FIELD_FILL_BITS-1:0] r_fill_high;

    logic                 accept;
    logic                 out_free;
    logic [CW-1:0]        cnt_sel;
    logic [CW:0]          fill_sum;
    logic                 is_full;
    logic                 pos_ok;
    logic [CW-1:0]        pos_c;
    logic [63:0]          value_ext;
    logic [WORD_BITS-1:0] word_in;
    logic [63:0]          rdata_ext;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic                 go_read;
    logic [1:0]           imm_status;
    logic [CW-1:0]        n_count_low;
    logic [CW-1:0]        n_count_high;
    logic [CW-1:0]        idx;

    // output register frees when empty or being taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    // one transaction in flight at a time; a pending read holds the input,
    // and nothing is taken while reset is held
    assign o_in_stall = !i_rst_n || (r_state != S_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign cnt_sel   = i_stack_sel ? r_count_high : r_count_low;
    assign fill_sum  = {1'b0, r_count_low} + {1'b0, r_count_high};
    assign is_full   = (fill_sum >= {1'b0, DEPTH_C});
    assign pos_ok    = (i_position != '0) && (PW'(i_position) <= PW'(cnt_sel));
    assign pos_c     = CW'(i_position);
    assign value_ext = {32'd0, i_value};
    assign word_in   = value_ext[WORD_BITS-1:0];
    assign rdata_ext = 64'(r_rdata);

    // operation decode; index arithmetic in count width, then truncated
    always_comb begin
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        go_read      = 1'b0;
        imm_status   = ST_OK;
        n_count_low  = r_count_low;
        n_count_high = r_count_high;
        idx          = '0;
        unique case (t_mode'(i_mode))
            MODE_PUSH: begin
                if (is_full) begin
                    imm_status = ST_FULL;
                end else if (i_stack_sel) begin
                    n_count_high = r_count_high + 1'b1;
                    idx          = DEPTH_C - n_count_high;
                    mem_we       = accept;
                end else begin
                    idx          = r_count_low;
                    n_count_low  = r_count_low + 1'b1;
                    mem_we       = accept;
                end
            end
            MODE_POP, MODE_PEEK: begin
                if (cnt_sel == '0) begin
                    imm_status = ST_EMPTY;
                end else begin
                    idx     = i_stack_sel ? (DEPTH_C - cnt_sel) : (cnt_sel - 1'b1);
                    mem_re  = accept;
                    go_read = 1'b1;
                    // pop retires the top entry now; the read still sees it
                    if (t_mode'(i_mode) == MODE_POP) begin
                        if (i_stack_sel) begin
                            n_count_high = r_count_high - 1'b1;
                        end else begin
                            n_count_low = r_count_low - 1'b1;
                        end
                    end
                end
            end
            MODE_MODIFY: begin
                if (cnt_sel == '0) begin
                    imm_status = ST_EMPTY;
                end else if (!pos_ok) begin
                    imm_status = ST_BADPOS;
                end else begin
                    idx    = i_stack_sel ? (DEPTH_C - pos_c) : (pos_c - 1'b1);
                    mem_we = accept;
                end
            end
            default: begin
                imm_status = ST_OK;
            end
        endcase
        mem_waddr = idx[AW-1:0];
        mem_raddr = idx[AW-1:0];
    end

    // shared memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= word_in;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // controller: state, counts and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count_low  <= '0;
            r_count_high <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_count_low  <= n_count_low;
                        r_count_high <= n_count_high;
                        if (go_read) begin
                            r_state <= S_READ;
                            if (!i_out_stall) begin
                                r_out_valid <= 1'b0;
                            end
                        end else begin
                            r_out_valid <= 1'b1;
                            r_status    <= imm_status;
                            r_data      <= '0;
                            r_fill_low  <= FIELD_FILL_BITS'(n_count_low);
                            r_fill_high <= FIELD_FILL_BITS'(n_count_high);
                        end
                    end else if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    // memory data is registered; it holds until taken
                    if (out_free) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_status    <= ST_OK;
                        r_data      <= rdata_ext[FIELD_DATA_BITS-1:0];
                        r_fill_low  <= FIELD_FILL_BITS'(r_count_low);
                        r_fill_high <= FIELD_FILL_BITS'(r_count_high);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_fill_low  = r_fill_low;
    assign o_fill_high = r_fill_high;

endmodule : dual_stack_shared_memory
